[rtl/assert_macros.svh]
// Assertion helpers included by the delta coder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

[rtl/mdc_pkg.sv]
`timescale 1ns / 1ps

package mdc_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 4;

    localparam logic [1:0] REG_ELEMENT_BYTES = 2'd0;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
    localparam logic [1:0] REG_DECODE_MODE   = 2'd2;

    localparam logic [2:0] ELEMENT_BYTES_RESET = 3'd1;
    localparam logic [4:0] CHANNEL_COUNT_RESET = 5'd1;

    typedef struct packed {
        logic [2:0] element_bytes;
        logic [4:0] channel_count;
        logic       decode_mode;
    } cfg_t;

    // Mask of the element width; a byte count of zero acts as one and
    // anything above four acts as four.
    function automatic logic [DATA_W-1:0] width_mask(input logic [2:0] element_bytes);
        logic [DATA_W-1:0] mask;
        case (element_bytes)
            3'd0, 3'd1: mask = 32'h0000_00FF;
            3'd2:       mask = 32'h0000_FFFF;
            3'd3:       mask = 32'h00FF_FFFF;
            default:    mask = 32'hFFFF_FFFF;
        endcase
        return mask;
    endfunction

endpackage

[rtl/mdc_cfg_regs.sv]
`timescale 1ns / 1ps

module mdc_cfg_regs
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mdc_pkg::ADDR_W-1:0] paddr,
    input  logic [mdc_pkg::DATA_W-1:0] pwdata,
    output logic [mdc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output mdc_pkg::cfg_t              cfg
);

    mdc_pkg::cfg_t cfg_reg;
    mdc_pkg::cfg_t cfg_next;
    logic          wr_en;
    logic [1:0]    reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en && (paddr[1:0] == 2'b00))
        begin
            unique case (reg_sel)
                mdc_pkg::REG_ELEMENT_BYTES: cfg_next.element_bytes = pwdata[2:0];
                mdc_pkg::REG_CHANNEL_COUNT: cfg_next.channel_count = pwdata[4:0];
                mdc_pkg::REG_DECODE_MODE:   cfg_next.decode_mode   = pwdata[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.element_bytes <= mdc_pkg::ELEMENT_BYTES_RESET;
            cfg_reg.channel_count <= mdc_pkg::CHANNEL_COUNT_RESET;
            cfg_reg.decode_mode   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            mdc_pkg::REG_ELEMENT_BYTES: prdata = {29'd0, cfg_reg.element_bytes};
            mdc_pkg::REG_CHANNEL_COUNT: prdata = {27'd0, cfg_reg.channel_count};
            mdc_pkg::REG_DECODE_MODE:   prdata = {31'd0, cfg_reg.decode_mode};
            default:                    prdata = '0;
        endcase
    end

endmodule

[rtl/multichannel_delta_coder_core.sv]
`timescale 1ns / 1ps
// An accepted request is held in stage one; its result goes to the output register.
// Throughput: one request per cycle unless the output stalls; the next channel's
// base is read from memory at acceptance; a write by the request ahead is forwarded.
// Reset: asynchronous, active low; restores configuration defaults and clears the
// channel index, pipeline valids and per-channel valid bits, so every stored base reads as zero.
`include "assert_macros.svh"

module multichannel_delta_coder_core
#(
    parameter int MAX_CHANNELS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mdc_pkg::ADDR_W-1:0] paddr,
    input  logic [mdc_pkg::DATA_W-1:0] pwdata,
    output logic [mdc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [31:0]                element_value,
    input  logic                       buffer_start,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [31:0]                coded_value
);

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CMP_W = (IDX_W + 1 > 6) ? IDX_W + 1 : 6;

    mdc_pkg::cfg_t cfg;

    mdc_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [31:0]             mask;
    logic [CMP_W-1:0]        chan_cnt_ext;
    logic [CMP_W-1:0]        eff_count;
    logic [IDX_W-1:0]        idx_cand;
    logic [IDX_W-1:0]        ch_sel;
    logic [IDX_W-1:0]        ch_inc;

    logic [IDX_W-1:0]        channel_index_reg;
    logic [IDX_W-1:0]        channel_index_next;
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic [31:0]             s1_value_reg;
    logic [IDX_W-1:0]        s1_ch_reg;
    logic                    s1_fwd_reg;
    logic [31:0]             s1_fwd_data_reg;
    logic [31:0]             base_rd_reg;
    logic                    base_vld_rd_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [31:0]             coded_value_reg;
    logic [MAX_CHANNELS-1:0] base_vld_reg;

    logic [31:0]             base_mem [MAX_CHANNELS];

    logic                    accept;
    logic                    s1_adv;
    logic [31:0]             base_raw;
    logic [31:0]             base_use;
    logic [31:0]             result;
    logic [31:0]             new_base;

    assign mask = mdc_pkg::width_mask(cfg.element_bytes);

    // Effective channel count, clamped to one .. MAX_CHANNELS.
    assign chan_cnt_ext = CMP_W'(cfg.channel_count);
    always_comb
    begin
        if (chan_cnt_ext == '0)
        begin
            eff_count = CMP_W'(1);
        end
        else if (chan_cnt_ext > CMP_W'(MAX_CHANNELS))
        begin
            eff_count = CMP_W'(MAX_CHANNELS);
        end
        else
        begin
            eff_count = chan_cnt_ext;
        end
    end

    always_comb
    begin
        idx_cand = buffer_start ? '0 : channel_index_reg;
        ch_sel   = (CMP_W'(idx_cand) >= eff_count) ? '0 : idx_cand;
        ch_inc   = ch_sel + IDX_W'(1);
        if ((CMP_W'(ch_sel) + CMP_W'(1)) >= eff_count)
        begin
            channel_index_next = '0;
        end
        else
        begin
            channel_index_next = ch_inc;
        end
    end

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    // The request ahead writes its base at the same edge as this read, so its
    // value is captured for forwarding.
    assign base_raw = s1_fwd_reg ? s1_fwd_data_reg :
                      (base_vld_rd_reg ? base_rd_reg : 32'd0);
    assign base_use = base_raw & mask;

    always_comb
    begin
        if (cfg.decode_mode)
        begin
            result   = (s1_value_reg + base_use) & mask;
            new_base = result;
        end
        else
        begin
            result   = (s1_value_reg - base_use) & mask;
            new_base = s1_value_reg;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_index_reg <= '0;
            s1_valid_reg      <= 1'b0;
            s1_fwd_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
            base_vld_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                channel_index_reg <= channel_index_next;
                s1_fwd_reg        <= s1_adv && (s1_ch_reg == ch_sel);
            end
            if (s1_adv)
            begin
                base_vld_reg[s1_ch_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_value_reg    <= element_value & mask;
            s1_ch_reg       <= ch_sel;
            s1_fwd_data_reg <= new_base;
            base_vld_rd_reg <= base_vld_reg[ch_sel];
        end
        if (s1_adv)
        begin
            coded_value_reg <= result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            base_mem[s1_ch_reg] <= new_base;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            base_rd_reg <= base_mem[ch_sel];
        end
    end

    assign out_valid   = out_valid_reg;
    assign coded_value = coded_value_reg;

    `ASSERT_NEXT(a_accept_fills_stage, clk, rst_n, accept, s1_valid_reg)
    `ASSERT_NEXT(a_advance_fills_output, clk, rst_n, s1_adv, out_valid_reg)
    `ASSERT_IMPLIES(a_stall_blocks_input, clk, rst_n, s1_valid_reg && !s1_adv, !in_ready)
    `ASSERT_IMPLIES(a_fwd_same_channel, clk, rst_n, accept && s1_adv && (s1_ch_reg == ch_sel), s1_valid_reg)

endmodule
